// ===== sv/stl_pkg.sv =====
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants
// Channel and capacity sizing, action codes and the command word passed
// from the parser front end to the table back end.
// ----------------------------------------------------------------------------
package stl_pkg;

    localparam int CHANNELS  = 8;
    localparam int CAPACITY  = 256;

    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int POS_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int MEM_DEPTH = CHANNELS * CAPACITY;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);

    localparam logic [15:0] NO_NUMBER  = 16'hFFFF;
    localparam logic [7:0]  NO_CHANNEL = 8'd255;
    localparam logic [7:0]  CHAR_0     = 8'h30;
    localparam logic [7:0]  CHAR_9     = 8'h39;
    localparam logic [7:0]  CHAR_LF    = 8'h0A;
    localparam logic [7:0]  CHAR_CR    = 8'h0D;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_EOS   = 2'd2,
        ACT_READ  = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_READ   = 2'd2
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t         op;
        logic [CH_W-1:0] ch;
        logic [15:0]     value;
        logic            err;
        logic            loaded;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [0:0] {
        BK_IDLE = 1'b0,
        BK_READ = 1'b1
    } bk_state_t;

endpackage

// ===== sv/stl_front.sv =====
// ----------------------------------------------------------------------------
// stl_front: text parser front end
// Accepts beats, builds decimal numbers, tracks line channel and load state,
// and issues clear / append / read commands into the queue.
// ----------------------------------------------------------------------------
module stl_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,   // [7:0] text_byte, [15:8] read_channel
    input  logic [1:0]        s_axis_tuser,   // [1:0] action
    input  stl_pkg::q_status_t q_status,
    output logic              push,
    output stl_pkg::cmd_t     push_cmd
);
    import stl_pkg::*;

    logic [15:0] partial_reg,  partial_next;
    logic        digit_reg,    digit_next;
    logic        nl_reg,       nl_next;
    logic        after_nl_reg, after_nl_next;
    logic [7:0]  line_ch_reg,  line_ch_next;
    logic        done_reg,     done_next;

    logic        accept;
    logic [7:0]  text_byte;
    logic [7:0]  read_channel;
    logic        is_digit;
    logic        is_nl;
    logic [15:0] times_ten;
    logic        take_en;
    logic [15:0] take_num;
    logic        take_nl;
    logic        nl_eff;

    assign s_axis_tready = !q_status.full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign text_byte     = s_axis_tdata[7:0];
    assign read_channel  = s_axis_tdata[15:8];
    assign is_digit      = (text_byte >= CHAR_0) && (text_byte <= CHAR_9);
    assign is_nl         = (text_byte == CHAR_LF) || (text_byte == CHAR_CR);
    // x*10 as two shifts and an add, wrapping at 16 bits
    assign times_ten     = {partial_reg[12:0], 3'b000} + {partial_reg[14:0], 1'b0};
    assign nl_eff        = nl_reg || is_nl;

    always_comb
    begin
        partial_next  = partial_reg;
        digit_next    = digit_reg;
        nl_next       = nl_reg;
        after_nl_next = after_nl_reg;
        line_ch_next  = line_ch_reg;
        done_next     = done_reg;
        push          = 1'b0;
        push_cmd      = '0;
        take_en       = 1'b0;
        take_num      = partial_reg;
        take_nl       = nl_reg;

        if (accept)
        begin
            unique case (act_t'(s_axis_tuser))
                ACT_CLEAR:
                begin
                    push          = 1'b1;
                    push_cmd.op   = CMD_CLEAR;
                    partial_next  = NO_NUMBER;
                    digit_next    = 1'b0;
                    nl_next       = 1'b0;
                    after_nl_next = 1'b0;
                    line_ch_next  = NO_CHANNEL;
                    done_next     = 1'b0;
                end
                ACT_BYTE:
                begin
                    if (!done_reg)
                    begin
                        if (is_digit)
                        begin
                            if (partial_reg == NO_NUMBER)
                                partial_next = {12'd0, text_byte[3:0]};
                            else
                                partial_next = times_ten + {12'd0, text_byte[3:0]};
                            digit_next = 1'b1;
                        end
                        else
                        begin
                            nl_next = nl_eff;
                            if (digit_reg)
                            begin
                                take_en      = 1'b1;
                                take_nl      = nl_eff;
                                partial_next = NO_NUMBER;
                                digit_next   = 1'b0;
                                nl_next      = 1'b0;
                            end
                        end
                    end
                end
                ACT_EOS:
                begin
                    if (!done_reg)
                    begin
                        take_en      = 1'b1;
                        partial_next = NO_NUMBER;
                        digit_next   = 1'b0;
                        nl_next      = 1'b0;
                        done_next    = 1'b1;
                    end
                end
                ACT_READ:
                begin
                    push            = 1'b1;
                    push_cmd.op     = CMD_READ;
                    push_cmd.ch     = read_channel[CH_W-1:0];
                    push_cmd.err    = (read_channel >= 8'(CHANNELS));
                    push_cmd.loaded = done_reg;
                end
                default: ;
            endcase

            // completed number: channel select or table append
            if (take_en && (take_num != NO_NUMBER))
            begin
                if (after_nl_reg || (line_ch_reg == NO_CHANNEL))
                begin
                    line_ch_next  = take_num[7:0];
                    after_nl_next = 1'b0;
                end
                else if (line_ch_reg < 8'(CHANNELS))
                begin
                    push           = 1'b1;
                    push_cmd.op    = CMD_APPEND;
                    push_cmd.ch    = line_ch_reg[CH_W-1:0];
                    push_cmd.value = take_num;
                end
                if (take_nl)
                    after_nl_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg  <= NO_NUMBER;
            digit_reg    <= 1'b0;
            nl_reg       <= 1'b0;
            after_nl_reg <= 1'b0;
            line_ch_reg  <= NO_CHANNEL;
            done_reg     <= 1'b0;
        end
        else
        begin
            partial_reg  <= partial_next;
            digit_reg    <= digit_next;
            nl_reg       <= nl_next;
            after_nl_reg <= after_nl_next;
            line_ch_reg  <= line_ch_next;
            done_reg     <= done_next;
        end
    end

endmodule

// ===== sv/stl_queue.sv =====
// ----------------------------------------------------------------------------
// stl_queue: command queue
// Small FIFO of command words between the parser and the table engine.
// ----------------------------------------------------------------------------
module stl_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  stl_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output stl_pkg::cmd_t      pop_cmd,
    output stl_pkg::q_status_t status
);
    import stl_pkg::*;

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg,   fill_next;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (fill_reg == (QPTR_W+1)'(QDEPTH));
    assign status.empty = (fill_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_cmd      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== sv/stl_back.sv =====
// ----------------------------------------------------------------------------
// stl_back: table engine
// Executes queued commands against the sample store, the per-channel fill
// counts and play positions, and drives the registered result beat.
// ----------------------------------------------------------------------------
module stl_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  stl_pkg::q_status_t q_status,
    input  stl_pkg::cmd_t      cmd,
    output logic               pop,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [15:0]        m_axis_tdata,  // [15:0] sample
    output logic [1:0]         m_axis_tuser   // [0] channel_error, [1] loaded
);
    import stl_pkg::*;

    bk_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg [CHANNELS];
    logic [CNT_W-1:0] count_next [CHANNELS];
    logic [POS_W-1:0] pos_reg [CHANNELS];
    logic [POS_W-1:0] pos_next [CHANNELS];

    logic             hit_reg,    hit_next;
    logic             err_reg,    err_next;
    logic             loaded_reg, loaded_next;
    logic             out_valid_reg, out_valid_next;
    logic [15:0]      out_sample_reg, out_sample_next;
    logic [1:0]       out_flags_reg,  out_flags_next;

    logic [15:0]      mem [MEM_DEPTH];
    logic [15:0]      rd_data_reg;
    logic             mem_we;
    logic             mem_re;
    logic [ADDR_W-1:0] mem_addr;

    logic [CNT_W-1:0] cur_cnt;
    logic [POS_W-1:0] cur_pos;
    logic [CNT_W-1:0] pos_inc;
    logic [ADDR_W-1:0] row_base;

    assign cur_cnt  = count_reg[cmd.ch];
    assign cur_pos  = pos_reg[cmd.ch];
    assign pos_inc  = CNT_W'(cur_pos) + 1'b1;
    assign row_base = ADDR_W'(cmd.ch) * ADDR_W'(CAPACITY);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sample_reg;
    assign m_axis_tuser  = out_flags_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        hit_next        = hit_reg;
        err_next        = err_reg;
        loaded_next     = loaded_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_sample_next = out_sample_reg;
        out_flags_next  = out_flags_reg;
        pop             = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = row_base + ADDR_W'(cur_cnt);

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop = 1'b1;
                    unique case (cmd.op)
                        CMD_CLEAR:
                        begin
                            for (int i = 0; i < CHANNELS; i++)
                            begin
                                count_next[i] = '0;
                                pos_next[i]   = '0;
                            end
                        end
                        CMD_APPEND:
                        begin
                            if (cur_cnt < CNT_W'(CAPACITY))
                            begin
                                mem_we              = 1'b1;
                                count_next[cmd.ch]  = cur_cnt + 1'b1;
                            end
                        end
                        CMD_READ:
                        begin
                            err_next    = cmd.err;
                            loaded_next = cmd.loaded;
                            hit_next    = 1'b0;
                            if (!cmd.err)
                            begin
                                mem_re   = 1'b1;
                                mem_addr = row_base + ADDR_W'(cur_pos);
                                hit_next = (cur_cnt != '0) && (CNT_W'(cur_pos) < cur_cnt);
                                // cyclic step through the filled part of the row
                                if (pos_inc >= cur_cnt)
                                    pos_next[cmd.ch] = '0;
                                else
                                    pos_next[cmd.ch] = pos_inc[POS_W-1:0];
                            end
                            state_next = BK_READ;
                        end
                        default: ;
                    endcase
                end
            end
            BK_READ:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = hit_reg ? rd_data_reg : 16'd0;
                    out_flags_next  = {loaded_reg, err_reg};
                    state_next      = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                count_reg[i] <= '0;
                pos_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg        <= hit_next;
        err_reg        <= err_next;
        loaded_reg     <= loaded_next;
        out_sample_reg <= out_sample_next;
        out_flags_reg  <= out_flags_next;
    end

    // sample store: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= cmd.value;
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            rd_data_reg <= mem[mem_addr];
    end

endmodule

// ===== sv/sample_table_loader_player_core.sv =====
// ----------------------------------------------------------------------------
// sample_table_loader_player_core: sample table loader and player
// Parses "channel: v1, v2, ..." text into per-channel sample tables and plays
// the stored samples back cyclically on request.
// ----------------------------------------------------------------------------
// Input beats carry an action in tuser: clear, text byte, end of stream or
// read. The front end takes one beat per cycle whenever its four-entry command
// queue has room, so text bytes stream in at full rate while the table engine
// works behind it. The engine does a clear or an append in its idle state; a
// read also passes through its read state (the sample store has a single port
// with a registered read) and takes no new command until its result is held in
// an output register. The engine keeps going with queued appends while a result
// waits. No clearing pass is needed after reset: fill counts and play
// positions are flip-flops cleared at once, and a stored sample is only
// returned below a channel's fill count.
// ----------------------------------------------------------------------------
module sample_table_loader_player_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] text_byte, [15:8] read_channel
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sample
    output logic [1:0]  m_axis_tuser    // [0] channel_error, [1] loaded
);
    import stl_pkg::*;

    logic      q_push;
    cmd_t      q_push_cmd;
    logic      q_pop;
    cmd_t      q_pop_cmd;
    q_status_t q_status;

    // parser: classifies beats and emits commands
    stl_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_status      (q_status),
        .push          (q_push),
        .push_cmd      (q_push_cmd)
    );

    // decouples parser from table engine
    stl_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .pop_cmd  (q_pop_cmd),
        .status   (q_status)
    );

    // table engine: store, counts, positions, result register
    stl_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .cmd           (q_pop_cmd),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // an invalid channel always reads as zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 16'd0)
        else $error("channel error with nonzero sample");

    // the parser never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("command queue overflow");

    // the engine never pops an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("command queue underflow");

    // a popped read command holds off the next pop
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && (q_pop_cmd.op == CMD_READ) |=> !q_pop)
        else $error("engine popped during read");

endmodule

// ===== tb/sv/sample_table_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_table_monitor: playback predictor and result compare
// Follows every accepted input beat, keeps its own copy of the channel tables
// and the text parser, and compares each result beat with the oldest sample
// predicted for a read.
// ----------------------------------------------------------------------------
module sample_table_monitor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] text_byte, [15:8] read_channel
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [15:0] sample
    input  logic [1:0]  m_axis_tuser,   // [0] channel_error, [1] loaded
    output int          mismatches,
    output int          pending
);
    import stl_pkg::*;

    typedef struct packed {
        logic [15:0] sample;
        logic        channel_error;
        logic        loaded;
    } playback_t;

    logic [15:0]  table_mem [CHANNELS][CAPACITY];
    int unsigned  fill      [CHANNELS];
    int unsigned  play_pos  [CHANNELS];
    logic [15:0]  number_acc;
    bit           digits_pending;
    bit           newline_seen;
    bit           line_start;
    logic [7:0]   cur_channel;
    bit           load_finished;

    playback_t    expected_samples [$];
    playback_t    want;
    playback_t    got;

    initial mismatches = 0;

    function automatic void restart_number();
        number_acc     = NO_NUMBER;
        digits_pending = 1'b0;
        newline_seen   = 1'b0;
    endfunction

    function automatic void restart_load();
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            fill[ch]     = 0;
            play_pos[ch] = 0;
        end
        restart_number();
        line_start    = 1'b0;
        cur_channel   = NO_CHANNEL;
        load_finished = 1'b0;
    endfunction

    // first number of a line picks the channel, the rest are appended
    function automatic void store_number(input logic [15:0] num, input bit nl);
        if (num == NO_NUMBER)
            return;
        if (line_start || cur_channel == NO_CHANNEL)
        begin
            cur_channel = num[7:0];
            line_start  = 1'b0;
        end
        else if (cur_channel < CHANNELS)
        begin
            if (fill[cur_channel] < CAPACITY)
            begin
                table_mem[cur_channel][fill[cur_channel]] = num;
                fill[cur_channel] = fill[cur_channel] + 1;
            end
        end
        if (nl)
            line_start = 1'b1;
    endfunction

    function automatic void parse_char(input logic [7:0] c);
        logic [15:0] digit;
        if (c >= CHAR_0 && c <= CHAR_9)
        begin
            digit = {8'd0, c - CHAR_0};
            if (number_acc == NO_NUMBER)
                number_acc = digit;
            else
                number_acc = number_acc * 16'd10 + digit;
            digits_pending = 1'b1;
        end
        else
        begin
            if (c == CHAR_LF || c == CHAR_CR)
                newline_seen = 1'b1;
            if (digits_pending)
            begin
                store_number(number_acc, newline_seen);
                restart_number();
            end
        end
    endfunction

    function automatic playback_t play_sample(input logic [7:0] rc);
        playback_t r;
        r.sample        = '0;
        r.channel_error = 1'b0;
        r.loaded        = load_finished;
        if (rc >= CHANNELS)
            r.channel_error = 1'b1;
        else
        begin
            if (fill[rc] != 0 && play_pos[rc] < fill[rc])
                r.sample = table_mem[rc][play_pos[rc]];
            play_pos[rc] = play_pos[rc] + 1;
            if (play_pos[rc] >= fill[rc])
                play_pos[rc] = 0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_load();
            expected_samples.delete();
            pending <= 0;
        end
        else
        begin
            // results first: a read accepted on this edge cannot answer yet
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]};
                if (expected_samples.size() == 0)
                begin
                    $error("result beat with no read waiting: sample %0d", got.sample);
                    mismatches++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (got.sample !== want.sample)
                    begin
                        $error("sample: expected %0d, got %0d", want.sample, got.sample);
                        mismatches++;
                    end
                    if (got.channel_error !== want.channel_error)
                    begin
                        $error("channel_error: expected %0d, got %0d",
                               want.channel_error, got.channel_error);
                        mismatches++;
                    end
                    if (got.loaded !== want.loaded)
                    begin
                        $error("loaded: expected %0d, got %0d", want.loaded, got.loaded);
                        mismatches++;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                case (act_t'(s_axis_tuser))
                    ACT_CLEAR:
                        restart_load();
                    ACT_BYTE:
                        if (!load_finished)
                            parse_char(s_axis_tdata[7:0]);
                    ACT_EOS:
                        if (!load_finished)
                        begin
                            store_number(number_acc, newline_seen);
                            restart_number();
                            load_finished = 1'b1;
                        end
                    ACT_READ:
                        expected_samples.push_back(play_sample(s_axis_tdata[15:8]));
                    default: ;
                endcase
            end

            pending <= expected_samples.size();
        end
    end

endmodule

// ===== tb/sv/sample_table_loader_player_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_table_loader_player_core_tb: stimulus and verdict
// Feeds text lines, noise, end-of-stream, clear and read beats to the loader
// and player, with random gaps on the input side and random backpressure on
// the result side; a separate monitor predicts and compares every sample.
// ----------------------------------------------------------------------------
module sample_table_loader_player_core_tb;

    import stl_pkg::*;

    // no handshake on either side for this long means the block is stuck
    localparam int STALL_LIMIT = 5000;
    // tail wait: room for four queued commands to finish, plus margin
    localparam int TAIL_CYCLES = 24;
    localparam int PHASE_BEATS = 20;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata   = '0;   // [7:0] text_byte, [15:8] read_channel
    logic [1:0]  s_axis_tuser   = '0;   // [1:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [15:0] m_axis_tdata;          // [15:0] sample
    logic [1:0]  m_axis_tuser;          // [0] channel_error, [1] loaded

    int          mismatches;
    int          pending;
    int          sender_idle_pct   = 0;
    int          receiver_stall_pct = 0;
    int          beats_sent        = 0;
    int          quiet_cycles      = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    sample_table_loader_player_core DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    sample_table_monitor tables_model
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // result side backpressure, redrawn every cycle
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);

    // watchdog: any accepted beat on either side resets the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("sample_table_loader_player_core_tb failed");
                $finish;
            end
        end
    end

    // One input beat. Called right after a rising edge; optional idle cycles
    // first, then hold tvalid until the block takes the beat.
    task automatic send_beat(input act_t act, input logic [7:0] text_byte,
                             input logic [7:0] read_channel);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {read_channel, text_byte};
        s_axis_tuser  <= act;
        do
            @(posedge clk);
        while (!s_axis_tready);
        beats_sent++;
    endtask

    // unused fields get random content; the block must ignore them
    task automatic send_char(input logic [7:0] c);
        send_beat(ACT_BYTE, c, 8'($urandom_range(255)));
    endtask

    task automatic send_read(input logic [7:0] ch);
        send_beat(ACT_READ, 8'($urandom_range(255)), ch);
    endtask

    task automatic send_control(input act_t act);
        send_beat(act, 8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    // decimal text of a number, most significant digit first
    task automatic send_decimal(input int unsigned value);
        logic [7:0]  digits [10];
        int          n;
        int unsigned v;
        int unsigned r;
        v = value;
        n = 0;
        do
        begin
            r = v % 10;
            digits[n] = CHAR_0 + r[7:0];
            v = v / 10;
            n++;
        end
        while (v != 0);
        for (int i = n - 1; i >= 0; i--)
            send_char(digits[i]);
    endtask

    // Sample values: mostly short, some full range, plus the no-number code,
    // values that wrap past 16 bits, one that wraps onto the no-number code
    // and one that restarts from a digit after passing through it.
    function automatic int unsigned pick_value();
        case ($urandom_range(11))
            0, 1, 2, 3, 4: return $urandom_range(99);
            5, 6:          return $urandom_range(65535);
            7:             return 65535;
            8, 9:          return $urandom_range(9999999, 65536);
            10:            return 131071;
            default:       return 655357;
        endcase
    endfunction

    // valid channels mostly; some out of range and the "none yet" code
    function automatic int unsigned pick_channel();
        case ($urandom_range(9))
            0:       return $urandom_range(300);
            1:       return 255;
            default: return $urandom_range(CHANNELS - 1);
        endcase
    endfunction

    // one "channel: v1, v2, ..." line, sometimes with a newline up front
    // and sometimes missing its line end
    task automatic send_line();
        int n;
        if ($urandom_range(3) == 0)
            send_char($urandom_range(1) ? CHAR_LF : CHAR_CR);
        send_decimal(pick_channel());
        send_char(":");
        if ($urandom_range(1))
            send_char(" ");
        n = $urandom_range(6, 1);
        for (int i = 0; i < n; i++)
        begin
            send_decimal(pick_value());
            if (i < n - 1)
            begin
                send_char(",");
                if ($urandom_range(1))
                    send_char(" ");
            end
        end
        case ($urandom_range(4))
            0: send_char(CHAR_LF);
            1: send_char(CHAR_LF);
            2: begin send_char(CHAR_CR); send_char(CHAR_LF); end
            3: send_char(CHAR_CR);
            default: ;
        endcase
    endtask

    task automatic send_reads();
        repeat ($urandom_range(6, 1))
            send_read(($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(CHANNELS - 1)));
    endtask

    // end of stream, a few beats the block must ignore, reads, then a new load
    task automatic finish_load();
        send_control(ACT_EOS);
        repeat ($urandom_range(2))
            send_char(CHAR_0 + 8'($urandom_range(9)));
        if ($urandom_range(1))
            send_control(ACT_EOS);
        send_reads();
        send_control(ACT_CLEAR);
    endtask

    // one channel pushed past its capacity, then played back
    task automatic overfill_channel();
        logic [7:0] ch;
        ch = 8'($urandom_range(CHANNELS - 1));
        send_control(ACT_CLEAR);
        send_decimal(ch);
        send_char(":");
        repeat (CAPACITY + 4)
        begin
            send_char(CHAR_0 + 8'($urandom_range(9)));
            send_char(",");
        end
        send_char(CHAR_LF);
        repeat (12)
            send_read(ch);
        send_read(8'($urandom_range(CHANNELS - 1)));
    endtask

    // stop sending until every predicted sample has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int idle_pct, input int stall_pct);
        int goal;
        int k;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        goal = beats_sent + PHASE_BEATS;
        while (beats_sent < goal)
        begin
            k = $urandom_range(99);
            if (k < 45)
                send_line();
            else if (k < 75)
                send_reads();
            else if (k < 84)
                send_char(8'($urandom_range(255)));
            else if (k < 89)
                send_char(CHAR_0 + 8'($urandom_range(9)));
            else if (k < 95)
                finish_load();
            else
                send_control(ACT_CLEAR);
        end
        wait_drained();
    endtask

    task automatic run_directed();
        // empty table and channels out of range, including the largest
        send_read(8'd0);
        send_read(8'd255);
        send_read(8'd8);
        // channel 1, a value wrapping past 16 bits, then the no-number code
        send_decimal(1);
        send_char(":");
        send_decimal(999999);
        send_char(",");
        send_decimal(65535);
        send_char(",");
        // extreme byte values act as plain separators
        send_char(8'h00);
        send_char(8'hFF);
        // newline ahead of the digits; end of stream flushes the number
        send_char(CHAR_CR);
        send_decimal(5);
        send_control(ACT_EOS);
        // ignored once loaded
        send_char(CHAR_9);
        send_control(ACT_EOS);
        // cyclic playback with loaded set
        send_read(8'd1);
        send_read(8'd1);
        send_read(8'd1);
        send_control(ACT_CLEAR);
        send_read(8'd1);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_drained();

        // no idling, with one table filled beyond capacity
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        overfill_channel();
        run_random(0, 0);
        // sparse input, then heavy backpressure, then light gaps on both
        run_random(77, 0);
        run_random(0, 77);
        run_random(8, 8);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("sample_table_loader_player_core_tb passed");
        else
            $display("sample_table_loader_player_core_tb failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/stl_pkg.sv
sv/stl_front.sv
sv/stl_queue.sv
sv/stl_back.sv
sv/sample_table_loader_player_core.sv
tb/sv/sample_table_monitor.sv
tb/sv/sample_table_loader_player_core_tb.sv
